[rtl/core/sas_pkg.sv]
// ----------------------------------------------------------------------------
// sas_pkg
// Shared types and codes for the session aging step pipeline.
// ----------------------------------------------------------------------------
package sas_pkg;

	localparam int TIME_W    = 48;
	localparam int CFG_IDX_W = 3;

	// protocol classes
	localparam logic [1:0] CLS_TCP   = 2'd0;
	localparam logic [1:0] CLS_ICMP  = 2'd1;
	localparam logic [1:0] CLS_UDP   = 2'd2;
	localparam logic [1:0] CLS_OTHER = 2'd3;

	// tcp session states
	localparam logic [2:0] TCP_CLOSED    = 3'd0;
	localparam logic [2:0] TCP_TRANSIENT = 3'd1;
	localparam logic [2:0] TCP_OPEN      = 3'd2;
	localparam logic [2:0] TCP_ENDING    = 3'd3;
	localparam logic [2:0] TCP_FREE      = 3'd4;

	// states of the other classes
	localparam logic [2:0] OTH_CLOSED   = 3'd0;
	localparam logic [2:0] OTH_TRANSMIT = 3'd1;
	localparam logic [2:0] OTH_IDLE     = 3'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TCP_TRANSIENT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TCP_OPEN      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TCP_ENDING    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ICMP          = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UDP           = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OTHER         = 3'd5;

	// register reset values, whole seconds
	localparam int RST_TCP_TRANSIENT = 240;
	localparam int RST_TCP_OPEN      = 7440;
	localparam int RST_TCP_ENDING    = 15;
	localparam int RST_ICMP          = 60;
	localparam int RST_UDP           = 300;
	localparam int RST_OTHER         = 300;

	typedef struct packed {
		logic [1:0] proto_class;
		logic [2:0] session_state;
	} sess_ctrl_t;

endpackage

[rtl/core/sas_in_if.sv]
// ----------------------------------------------------------------------------
// sas_in_if
// Input item channel: one expired session per item.
// ----------------------------------------------------------------------------
interface sas_in_if #(
	parameter int TMO_W = 24
);
	import sas_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        proto_class;
	logic [2:0]        session_state;
	logic [TIME_W-1:0] now_time;
	logic [TIME_W-1:0] last_packet_time;
	logic [TMO_W-1:0]  running_timeout;
	logic              override_valid;
	logic [TMO_W-1:0]  override_timeout;

	modport source (
		output valid, proto_class, session_state, now_time, last_packet_time,
		       running_timeout, override_valid, override_timeout,
		input  ready
	);

	modport sink (
		input  valid, proto_class, session_state, now_time, last_packet_time,
		       running_timeout, override_valid, override_timeout,
		output ready
	);
endinterface

[rtl/core/sas_out_if.sv]
// ----------------------------------------------------------------------------
// sas_out_if
// Result item channel: new state, delete flag and timers.
// ----------------------------------------------------------------------------
interface sas_out_if #(
	parameter int TMO_W = 24
);
	logic             valid;
	logic             ready;
	logic [2:0]       next_state;
	logic             delete_session;
	logic [TMO_W-1:0] rearm_timeout;
	logic [TMO_W-1:0] new_running_timeout;

	modport source (
		output valid, next_state, delete_session, rearm_timeout, new_running_timeout,
		input  ready
	);

	modport sink (
		input  valid, next_state, delete_session, rearm_timeout, new_running_timeout,
		output ready
	);
endinterface

[rtl/core/sas_cfg_if.sv]
// ----------------------------------------------------------------------------
// sas_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface sas_cfg_if #(
	parameter int TMO_W = 24
);
	import sas_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] idx;
	logic [TMO_W-1:0]     wdata;

	modport source (
		output valid, idx, wdata,
		input  ready
	);

	modport sink (
		input  valid, idx, wdata,
		output ready
	);
endinterface

[rtl/core/session_aging_step.sv]
// ----------------------------------------------------------------------------
// session_aging_step
// Ages one expired flow session per item: new state, delete flag, timers.
// ----------------------------------------------------------------------------
// Usage:
//   items_in  carries one expired session: class, state, now and last
//             packet time (fixed point), running timeout and override.
//   results   returns one item per input item, in order: next state,
//             delete flag, re-arm timeout and updated running timeout.
//   cfg       writes the six timeout registers; ready is always high.
//             Write only while no item is in flight.
// Pipeline: three register stages (idle time, compare/subtract, state rule).
// Throughput is one item per cycle while the receiver takes results; each stage has its own valid bit.
// A stalled receiver holds the result register; ready runs back through
// every stage in the same cycle, so a stage with room still takes an item
// and nothing is lost or repeated.
// Reset clears all valid bits and loads the default timeouts.
// ----------------------------------------------------------------------------
module session_aging_step #(
	parameter int TIME_FRAC_BITS = 16,
	parameter int TIMEOUT_BITS   = 24
) (
	input  logic     clk,
	input  logic     arst_n,
	sas_in_if.sink   items_in,
	sas_out_if.source results,
	sas_cfg_if.sink  cfg
);
	import sas_pkg::*;

	localparam int TMO_W = TIMEOUT_BITS;

	logic [TMO_W-1:0]  est_tmo;
	logic [TMO_W-1:0]  closing_tmo;
	logic [TMO_W-1:0]  icmp_tmo;
	logic [TMO_W-1:0]  udp_tmo;
	logic [TMO_W-1:0]  other_tmo;

	sess_ctrl_t        in_ctrl;
	sess_ctrl_t        ctrl_1;
	sess_ctrl_t        ctrl_2;
	logic              vld_1;
	logic              rdy_1;
	logic              vld_2;
	logic              rdy_2;
	logic [TIME_W-1:0] idle_1;
	logic [TMO_W-1:0]  old_1;
	logic [TMO_W-1:0]  base_1;
	logic [TMO_W-1:0]  close_1;
	logic              reached_2;
	logic              shorten_2;
	logic              gt_2;
	logic [TMO_W-1:0]  short_2;
	logic [TMO_W-1:0]  base_2;
	logic [TMO_W-1:0]  old_2;
	logic [TMO_W-1:0]  close_2;
	logic [2:0]        orig_state;

	assign in_ctrl.proto_class   = items_in.proto_class;
	assign in_ctrl.session_state = items_in.session_state;

	sas_cfg_regs #(
		.TMO_W (TMO_W)
	) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.est_tmo     (est_tmo),
		.closing_tmo (closing_tmo),
		.icmp_tmo    (icmp_tmo),
		.udp_tmo     (udp_tmo),
		.other_tmo   (other_tmo)
	);

	sas_idle_stage #(
		.TMO_W (TMO_W)
	) u_idle (
		.clk              (clk),
		.arst_n           (arst_n),
		.up_valid         (items_in.valid),
		.up_ready         (items_in.ready),
		.up_ctrl          (in_ctrl),
		.now_time         (items_in.now_time),
		.last_packet_time (items_in.last_packet_time),
		.running_timeout  (items_in.running_timeout),
		.override_valid   (items_in.override_valid),
		.override_timeout (items_in.override_timeout),
		.est_tmo          (est_tmo),
		.closing_tmo      (closing_tmo),
		.icmp_tmo         (icmp_tmo),
		.udp_tmo          (udp_tmo),
		.other_tmo        (other_tmo),
		.dn_valid         (vld_1),
		.dn_ready         (rdy_1),
		.dn_ctrl          (ctrl_1),
		.idle             (idle_1),
		.old_tmo          (old_1),
		.base_tmo         (base_1),
		.close_rearm      (close_1)
	);

	sas_test_stage #(
		.TMO_W  (TMO_W),
		.FRAC_W (TIME_FRAC_BITS)
	) u_test (
		.clk         (clk),
		.arst_n      (arst_n),
		.up_valid    (vld_1),
		.up_ready    (rdy_1),
		.up_ctrl     (ctrl_1),
		.idle        (idle_1),
		.old_tmo     (old_1),
		.base_tmo    (base_1),
		.close_rearm (close_1),
		.dn_valid    (vld_2),
		.dn_ready    (rdy_2),
		.dn_ctrl     (ctrl_2),
		.reached     (reached_2),
		.shorten     (shorten_2),
		.base_gt     (gt_2),
		.short_tmo   (short_2),
		.base_out    (base_2),
		.old_out     (old_2),
		.close_out   (close_2)
	);

	sas_result_stage #(
		.TMO_W (TMO_W)
	) u_result (
		.clk                 (clk),
		.arst_n              (arst_n),
		.up_valid            (vld_2),
		.up_ready            (rdy_2),
		.up_ctrl             (ctrl_2),
		.reached             (reached_2),
		.shorten             (shorten_2),
		.base_gt             (gt_2),
		.short_tmo           (short_2),
		.base_tmo            (base_2),
		.old_tmo             (old_2),
		.close_rearm         (close_2),
		.dn_valid            (results.valid),
		.dn_ready            (results.ready),
		.next_state          (results.next_state),
		.delete_session      (results.delete_session),
		.rearm_timeout       (results.rearm_timeout),
		.new_running_timeout (results.new_running_timeout),
		.session_state       (orig_state)
	);

`ifndef NO_ASSERTIONS
	a_deleted_state: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.delete_session |-> results.next_state == orig_state)
		else $error("deleted session changed state");

	a_stage_order: assert property (@(posedge clk) disable iff (!arst_n)
		vld_2 && !rdy_2 |-> results.valid && !results.ready)
		else $error("stage two stalled without a blocked result");

	a_entry_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!items_in.ready |-> vld_1 && vld_2 && results.valid)
		else $error("input blocked while a stage is empty");
`endif

endmodule

[rtl/core/sas_cfg_regs.sv]
// ----------------------------------------------------------------------------
// sas_cfg_regs
// Timeout register file written through the configuration channel.
// ----------------------------------------------------------------------------
module sas_cfg_regs #(
	parameter int TMO_W = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	sas_cfg_if.sink          cfg,
	output logic [TMO_W-1:0] est_tmo,
	output logic [TMO_W-1:0] closing_tmo,
	output logic [TMO_W-1:0] icmp_tmo,
	output logic [TMO_W-1:0] udp_tmo,
	output logic [TMO_W-1:0] other_tmo
);
	import sas_pkg::*;

	// transitory timeout is kept for software but never feeds a result
	logic [TMO_W-1:0] transitory_q;
	logic [TMO_W-1:0] est_q;
	logic [TMO_W-1:0] closing_q;
	logic [TMO_W-1:0] icmp_q;
	logic [TMO_W-1:0] udp_q;
	logic [TMO_W-1:0] other_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transitory_q <= TMO_W'(RST_TCP_TRANSIENT);
			est_q        <= TMO_W'(RST_TCP_OPEN);
			closing_q    <= TMO_W'(RST_TCP_ENDING);
			icmp_q       <= TMO_W'(RST_ICMP);
			udp_q        <= TMO_W'(RST_UDP);
			other_q      <= TMO_W'(RST_OTHER);
		end else if (cfg.valid) begin
			case (cfg.idx)
				REG_TCP_TRANSIENT: transitory_q <= cfg.wdata;
				REG_TCP_OPEN:      est_q        <= cfg.wdata;
				REG_TCP_ENDING:    closing_q    <= cfg.wdata;
				REG_ICMP:          icmp_q       <= cfg.wdata;
				REG_UDP:           udp_q        <= cfg.wdata;
				REG_OTHER:         other_q      <= cfg.wdata;
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	assign est_tmo     = est_q;
	assign closing_tmo = closing_q;
	assign icmp_tmo    = icmp_q;
	assign udp_tmo     = udp_q;
	assign other_tmo   = other_q;

endmodule

[rtl/core/sas_idle_stage.sv]
// ----------------------------------------------------------------------------
// sas_idle_stage
// Stage 1: idle time, base timeout selection and closing re-arm value.
// ----------------------------------------------------------------------------
module sas_idle_stage #(
	parameter int TMO_W = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      up_valid,
	output logic                      up_ready,
	input  sas_pkg::sess_ctrl_t       up_ctrl,
	input  logic [sas_pkg::TIME_W-1:0] now_time,
	input  logic [sas_pkg::TIME_W-1:0] last_packet_time,
	input  logic [TMO_W-1:0]          running_timeout,
	input  logic                      override_valid,
	input  logic [TMO_W-1:0]          override_timeout,
	input  logic [TMO_W-1:0]          est_tmo,
	input  logic [TMO_W-1:0]          closing_tmo,
	input  logic [TMO_W-1:0]          icmp_tmo,
	input  logic [TMO_W-1:0]          udp_tmo,
	input  logic [TMO_W-1:0]          other_tmo,
	output logic                      dn_valid,
	input  logic                      dn_ready,
	output sas_pkg::sess_ctrl_t       dn_ctrl,
	output logic [sas_pkg::TIME_W-1:0] idle,
	output logic [TMO_W-1:0]          old_tmo,
	output logic [TMO_W-1:0]          base_tmo,
	output logic [TMO_W-1:0]          close_rearm
);
	import sas_pkg::*;

	logic              vld_s1;
	sess_ctrl_t        ctrl_s1;
	logic [TIME_W-1:0] idle_s1;
	logic [TMO_W-1:0]  old_s1;
	logic [TMO_W-1:0]  base_s1;
	logic [TMO_W-1:0]  close_s1;

	logic [TIME_W:0]   diff;
	logic [TMO_W-1:0]  dflt;

	// borrow out means the last packet is in the future: idle is zero
	assign diff = {1'b0, now_time} - {1'b0, last_packet_time};

	always_comb begin
		case (up_ctrl.proto_class)
			CLS_TCP:  dflt = est_tmo;
			CLS_ICMP: dflt = icmp_tmo;
			CLS_UDP:  dflt = udp_tmo;
			default:  dflt = other_tmo;
		endcase
	end

	assign up_ready = !vld_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (up_ready) begin
			vld_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			ctrl_s1  <= up_ctrl;
			idle_s1  <= diff[TIME_W] ? '0 : diff[TIME_W-1:0];
			old_s1   <= running_timeout;
			base_s1  <= override_valid ? override_timeout : dflt;
			close_s1 <= (closing_tmo == '0) ? TMO_W'(1) : closing_tmo;
		end
	end

	assign dn_valid    = vld_s1;
	assign dn_ctrl     = ctrl_s1;
	assign idle        = idle_s1;
	assign old_tmo     = old_s1;
	assign base_tmo    = base_s1;
	assign close_rearm = close_s1;

endmodule

[rtl/core/sas_test_stage.sv]
// ----------------------------------------------------------------------------
// sas_test_stage
// Stage 2: timeout reach test, one-tenth test and idle-seconds subtract.
// ----------------------------------------------------------------------------
module sas_test_stage #(
	parameter int TMO_W  = 24,
	parameter int FRAC_W = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      up_valid,
	output logic                      up_ready,
	input  sas_pkg::sess_ctrl_t       up_ctrl,
	input  logic [sas_pkg::TIME_W-1:0] idle,
	input  logic [TMO_W-1:0]          old_tmo,
	input  logic [TMO_W-1:0]          base_tmo,
	input  logic [TMO_W-1:0]          close_rearm,
	output logic                      dn_valid,
	input  logic                      dn_ready,
	output sas_pkg::sess_ctrl_t       dn_ctrl,
	output logic                      reached,
	output logic                      shorten,
	output logic                      base_gt,
	output logic [TMO_W-1:0]          short_tmo,
	output logic [TMO_W-1:0]          base_out,
	output logic [TMO_W-1:0]          old_out,
	output logic [TMO_W-1:0]          close_out
);
	import sas_pkg::*;

	localparam int CMP_W = (TIME_W + 4 > TMO_W + FRAC_W) ? TIME_W + 4 : TMO_W + FRAC_W;

	logic              vld_s2;
	sess_ctrl_t        ctrl_s2;
	logic              reached_s2;
	logic              shorten_s2;
	logic              gt_s2;
	logic [TMO_W-1:0]  short_s2;
	logic [TMO_W-1:0]  base_s2;
	logic [TMO_W-1:0]  old_s2;
	logic [TMO_W-1:0]  close_s2;

	logic [CMP_W-1:0]  scaled;
	logic [CMP_W-1:0]  idle_w;
	logic [CMP_W-1:0]  idle_x10;
	logic [TIME_W-1:0] secs;

	assign scaled   = CMP_W'(old_tmo) << FRAC_W;
	assign idle_w   = CMP_W'(idle);
	assign idle_x10 = (idle_w << 3) + (idle_w << 1);
	assign secs     = idle >> FRAC_W;

	assign up_ready = !vld_s2 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (up_ready) begin
			vld_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			ctrl_s2    <= up_ctrl;
			reached_s2 <= idle_w >= scaled;
			shorten_s2 <= idle_x10 > scaled;
			gt_s2      <= TIME_W'(base_tmo) > secs;
			// only used when base exceeds secs, so the low bits are exact
			short_s2   <= base_tmo - secs[TMO_W-1:0];
			base_s2    <= base_tmo;
			old_s2     <= old_tmo;
			close_s2   <= close_rearm;
		end
	end

	assign dn_valid  = vld_s2;
	assign dn_ctrl   = ctrl_s2;
	assign reached   = reached_s2;
	assign shorten   = shorten_s2;
	assign base_gt   = gt_s2;
	assign short_tmo = short_s2;
	assign base_out  = base_s2;
	assign old_out   = old_s2;
	assign close_out = close_s2;

endmodule

[rtl/core/sas_result_stage.sv]
// ----------------------------------------------------------------------------
// sas_result_stage
// Stage 3: per-class state rule and the registered result item.
// ----------------------------------------------------------------------------
module sas_result_stage #(
	parameter int TMO_W = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	output logic                up_ready,
	input  sas_pkg::sess_ctrl_t up_ctrl,
	input  logic                reached,
	input  logic                shorten,
	input  logic                base_gt,
	input  logic [TMO_W-1:0]    short_tmo,
	input  logic [TMO_W-1:0]    base_tmo,
	input  logic [TMO_W-1:0]    old_tmo,
	input  logic [TMO_W-1:0]    close_rearm,
	output logic                dn_valid,
	input  logic                dn_ready,
	output logic [2:0]          next_state,
	output logic                delete_session,
	output logic [TMO_W-1:0]    rearm_timeout,
	output logic [TMO_W-1:0]    new_running_timeout,
	output logic [2:0]          session_state
);
	import sas_pkg::*;

	logic             vld_s3;
	logic [2:0]       state_s3;
	logic             del_s3;
	logic [TMO_W-1:0] rearm_s3;
	logic [TMO_W-1:0] nrun_s3;
	logic [2:0]       orig_s3;

	logic [TMO_W-1:0] act_base;
	logic [TMO_W-1:0] act_tmo;
	logic [2:0]       ns;
	logic             del;
	logic [TMO_W-1:0] rearm;
	logic [TMO_W-1:0] nrun;

	always_comb begin
		if (!shorten) begin
			act_base = base_tmo;
		end else if (base_gt) begin
			act_base = short_tmo;
		end else begin
			act_base = TMO_W'(1);
		end
		act_tmo = (act_base == '0) ? TMO_W'(1) : act_base;
	end

	always_comb begin
		ns    = up_ctrl.session_state;
		del   = 1'b0;
		rearm = '0;
		nrun  = old_tmo;
		if (up_ctrl.proto_class == CLS_TCP) begin
			case (up_ctrl.session_state)
				TCP_CLOSED, TCP_TRANSIENT: begin
					ns    = TCP_ENDING;
					rearm = close_rearm;
				end
				TCP_OPEN: begin
					if (reached) begin
						ns    = TCP_ENDING;
						rearm = close_rearm;
					end else begin
						nrun  = act_tmo;
						rearm = act_tmo;
					end
				end
				TCP_ENDING: begin
					ns    = TCP_FREE;
					rearm = TMO_W'(1);
				end
				default: del = 1'b1;
			endcase
		end else begin
			case (up_ctrl.session_state)
				OTH_CLOSED, OTH_TRANSMIT: begin
					if (reached) begin
						ns    = OTH_IDLE;
						rearm = TMO_W'(1);
					end else begin
						nrun  = act_tmo;
						rearm = act_tmo;
					end
				end
				default: del = 1'b1;
			endcase
		end
	end

	assign up_ready = !vld_s3 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (up_ready) begin
			vld_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			state_s3 <= ns;
			del_s3   <= del;
			rearm_s3 <= rearm;
			nrun_s3  <= nrun;
			orig_s3  <= up_ctrl.session_state;
		end
	end

	assign dn_valid            = vld_s3;
	assign next_state          = state_s3;
	assign delete_session      = del_s3;
	assign rearm_timeout       = rearm_s3;
	assign new_running_timeout = nrun_s3;
	assign session_state       = orig_s3;

`ifndef NO_ASSERTIONS
	a_del_no_timer: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && del_s3 |-> rearm_s3 == '0 && state_s3 == orig_s3)
		else $error("deleted session carries a timer or a new state");

	a_live_has_timer: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && !del_s3 |-> rearm_s3 != '0)
		else $error("live session re-armed with zero timeout");

	a_active_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && !del_s3 && state_s3 == orig_s3 |-> rearm_s3 == nrun_s3)
		else $error("active session re-arm differs from running timeout");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && !dn_ready |=> vld_s3 && $stable(rearm_s3) && $stable(state_s3))
		else $error("stalled result changed");
`endif

endmodule
